### sv/agt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agt_pkg
// Shared types and constants for the affine gap traceback block: path
// symbol codes, walk states, register indexes and the direction code set.
// ----------------------------------------------------------------------------
package agt_pkg;

    // configuration port geometry
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DIAG = 2'd0;
    localparam logic [1:0] REG_UP   = 2'd1;
    localparam logic [1:0] REG_LEFT = 2'd2;

    // reset values of the direction codes
    localparam logic [1:0] DIAG_RESET = 2'd0;
    localparam logic [1:0] UP_RESET   = 2'd1;
    localparam logic [1:0] LEFT_RESET = 2'd2;

    // path symbols
    localparam logic [1:0] SYM_MATCH = 2'd0;
    localparam logic [1:0] SYM_DEL   = 2'd1;
    localparam logic [1:0] SYM_INS   = 2'd2;
    localparam logic [1:0] SYM_ERR   = 2'd3;

    // walk states
    localparam logic [1:0] WALK_MM  = 2'd0;
    localparam logic [1:0] WALK_DEL = 2'd1;
    localparam logic [1:0] WALK_INS = 2'd2;

    // pointer bit positions
    localparam int unsigned PTR_DEL_EXT = 3;
    localparam int unsigned PTR_INS_EXT = 2;

    // direction codes as held by the register file
    typedef struct packed {
        logic [1:0] diag_code;
        logic [1:0] up_code;
        logic [1:0] left_code;
    } agt_codes_t;

endpackage : agt_pkg
`default_nettype wire

### sv/affine_gap_traceback.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_gap_traceback
// Pointer store plus a match / deletion / insertion walk that emits the
// alignment path from an end cell back to the matrix edge.
// ----------------------------------------------------------------------------
// A write item (func 0) stores one pointer; busy stays low. A start item
// (func 1) raises busy and walks the pointer store back from the end cell.
// Every cell visit has a fetch state to read the pointer RAM through its
// registered read port and an evaluate state; a state switch visits the cell
// again with no symbol. A run has at most QUERY_ROWS + REF_COLS - 1 symbols.
// Each symbol appears for one cycle with valid high and the receiver cannot
// stall it; the final symbol of a run has last set and busy drops in the
// cycle it is shown. Direction codes are to be written through the APB port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module affine_gap_traceback #(
    parameter int unsigned QUERY_ROWS = 32,
    parameter int unsigned REF_COLS   = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            func,
    input  wire logic [4:0]                      row_index,
    input  wire logic [4:0]                      col_index,
    input  wire logic [3:0]                      pointer_bits,
    // result channel
    output logic                                 valid,
    output logic [1:0]                           path_symbol,
    output logic                                 last,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [agt_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [agt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [agt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import agt_pkg::*;

    localparam int unsigned ROW_W   = $clog2(QUERY_ROWS);
    localparam int unsigned COL_W   = $clog2(REF_COLS);
    localparam int unsigned ADDR_W  = ROW_W + COL_W;
    localparam int unsigned DEPTH   = 1 << ADDR_W;
    localparam logic [5:0]  ROWS6   = 6'(QUERY_ROWS);
    localparam logic [5:0]  COLS6   = 6'(REF_COLS);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(QUERY_ROWS - 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(REF_COLS - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    agt_codes_t       codes;
    logic [1:0]       state_reg,  state_next;
    logic [1:0]       walk_reg,   walk_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    logic [COL_W-1:0] col_reg,    col_next;
    logic             valid_reg,  valid_next;
    logic [1:0]       sym_reg,    sym_next;
    logic             last_reg,   last_next;

    logic             accept;
    logic             row_ok;
    logic             col_ok;
    logic             ram_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic             ram_re;
    logic [3:0]       ptr;
    logic [1:0]       dir;

    // register file
    agt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .codes   (codes)
    );

    // command acceptance and write path
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;
    assign row_ok = ({1'b0, row_index} < ROWS6);
    assign col_ok = ({1'b0, col_index} < COLS6);
    assign ram_we = accept & ~func & row_ok & col_ok;
    assign waddr  = {row_index[ROW_W-1:0], col_index[COL_W-1:0]};
    assign raddr  = {row_reg, col_reg};
    assign ram_re = (state_reg == ST_FETCH);

    agt_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (pointer_bits),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ptr)
    );

    assign dir = ptr[1:0];

    // walk sequencer
    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        valid_next = 1'b0;
        sym_next   = sym_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func)
                begin
                    // saturate the end cell into the matrix
                    row_next   = row_ok ? row_index[ROW_W-1:0] : ROW_MAX;
                    col_next   = col_ok ? col_index[COL_W-1:0] : COL_MAX;
                    walk_next  = WALK_MM;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_FETCH;
                case (walk_reg)
                    WALK_MM:
                    begin
                        if (dir == codes.diag_code)
                        begin
                            valid_next = 1'b1;
                            sym_next   = SYM_MATCH;
                            last_next  = (row_reg == '0) || (col_reg == '0);
                            row_next   = row_reg - ROW_W'(1);
                            col_next   = col_reg - COL_W'(1);
                            if (last_next)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        else if (dir == codes.up_code)
                        begin
                            walk_next = WALK_DEL;
                        end
                        else if (dir == codes.left_code)
                        begin
                            walk_next = WALK_INS;
                        end
                        else
                        begin
                            // unknown direction ends the run
                            valid_next = 1'b1;
                            sym_next   = SYM_ERR;
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    WALK_DEL:
                    begin
                        valid_next = 1'b1;
                        sym_next   = SYM_DEL;
                        last_next  = (row_reg == '0);
                        walk_next  = ptr[PTR_DEL_EXT] ? WALK_DEL : WALK_MM;
                        row_next   = row_reg - ROW_W'(1);
                        if (last_next)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    WALK_INS:
                    begin
                        valid_next = 1'b1;
                        sym_next   = SYM_INS;
                        last_next  = (col_reg == '0);
                        walk_next  = ptr[PTR_INS_EXT] ? WALK_INS : WALK_MM;
                        col_next   = col_reg - COL_W'(1);
                        if (last_next)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // walk position and result payload
    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
    end

    assign valid       = valid_reg;
    assign path_symbol = sym_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    // a symbol that is not the last one leaves the walk running
    a_mid_symbol_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("walk stopped after a symbol without last");

    // the run ends exactly with a last symbol
    a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && $past(busy) |-> valid && last)
        else $error("walk ended without a last symbol");

    // an error symbol always closes the run
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (path_symbol == SYM_ERR) |-> last)
        else $error("error symbol without last");

    // symbols only come out of an evaluation step
    a_sym_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(state_reg == ST_EVAL))
        else $error("symbol issued outside evaluation");
`endif

endmodule : affine_gap_traceback
`default_nettype wire

### sv/agt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module agt_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : agt_ram
`default_nettype wire

### sv/agt_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agt_cfg
// APB register file holding the three direction codes used by the walk.
// ----------------------------------------------------------------------------
module agt_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [agt_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [agt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [agt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output agt_pkg::agt_codes_t                  codes
);
    import agt_pkg::*;

    agt_codes_t codes_reg;
    agt_codes_t codes_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // register write decode
    always_comb
    begin
        codes_next = codes_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_DIAG: codes_next.diag_code = pwdata[1:0];
                REG_UP:   codes_next.up_code   = pwdata[1:0];
                REG_LEFT: codes_next.left_code = pwdata[1:0];
                default:  codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.diag_code <= DIAG_RESET;
            codes_reg.up_code   <= UP_RESET;
            codes_reg.left_code <= LEFT_RESET;
        end
        else
        begin
            codes_reg <= codes_next;
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_DIAG: prdata[1:0] = codes_reg.diag_code;
            REG_UP:   prdata[1:0] = codes_reg.up_code;
            REG_LEFT: prdata[1:0] = codes_reg.left_code;
            default:  prdata = '0;
        endcase
    end

    assign codes = codes_reg;

endmodule : agt_cfg
`default_nettype wire

### dv/affine_gap_traceback_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_gap_traceback_checker
// Watches the command, result and APB channels of the traceback block. It
// keeps its own pointer store and direction codes and walks every accepted
// start item to the list of path symbols due. Each symbol shown by the block
// is compared with the oldest one due. Mismatches are counted for the test top.
// ----------------------------------------------------------------------------
module affine_gap_traceback_checker #(
    parameter int unsigned QUERY_ROWS = 32,
    parameter int unsigned REF_COLS   = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            func,
    input  wire logic [4:0]                      row_index,
    input  wire logic [4:0]                      col_index,
    input  wire logic [3:0]                      pointer_bits,
    input  wire logic                            valid,
    input  wire logic [1:0]                      path_symbol,
    input  wire logic                            last,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [agt_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [agt_pkg::APB_DATA_W-1:0]  pwdata,
    output int unsigned                          fail_count,
    output int unsigned                          symbols_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import agt_pkg::*;

    typedef struct packed {
        logic [1:0] symbol;
        logic       is_last;
    } path_step_t;

    path_step_t   path_due [$];
    logic [3:0]   cell_ptr [QUERY_ROWS*REF_COLS];
    logic [1:0]   diag_code = DIAG_RESET;
    logic [1:0]   up_code   = UP_RESET;
    logic [1:0]   left_code = LEFT_RESET;
    int unsigned  mismatches = 0;

    assign fail_count = mismatches;

    // direction to walk state, diag first, then up, then left
    function automatic logic decode_dir(input logic [1:0] dir, output logic [1:0] walk);
        walk = WALK_MM;
        if (dir == diag_code)
            walk = WALK_MM;
        else if (dir == up_code)
            walk = WALK_DEL;
        else if (dir == left_code)
            walk = WALK_INS;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    // append one symbol to the list of symbols due
    task automatic queue_step(input logic [1:0] sym, input logic fin);
        path_step_t step;
        step.symbol  = sym;
        step.is_last = fin;
        path_due.insert(path_due.size(), step);
    endtask

    // walk back from the end cell and queue the symbols it produces
    task automatic trace_back(input logic [4:0] r0, input logic [4:0] c0);
        int         row;
        int         col;
        logic [1:0] st;
        logic [1:0] nxt;
        logic [3:0] ptr;
        row = (r0 >= QUERY_ROWS) ? QUERY_ROWS - 1 : r0;
        col = (c0 >= REF_COLS) ? REF_COLS - 1 : c0;
        ptr = cell_ptr[row*REF_COLS + col];
        if (!decode_dir(ptr[1:0], st))
        begin
            queue_step(SYM_ERR, 1'b1);
            return;
        end
        while (row >= 0 && col >= 0)
        begin
            ptr = cell_ptr[row*REF_COLS + col];
            if (st == WALK_MM)
            begin
                if (!decode_dir(ptr[1:0], nxt))
                begin
                    queue_step(SYM_ERR, 1'b1);
                    return;
                end
                if (nxt == WALK_MM)
                begin
                    queue_step(SYM_MATCH, 1'b0);
                    row--;
                    col--;
                end
                else
                begin
                    // state switch, no symbol and no move
                    st = nxt;
                end
            end
            else if (st == WALK_DEL)
            begin
                queue_step(SYM_DEL, 1'b0);
                if (!ptr[PTR_DEL_EXT])
                    st = WALK_MM;
                row--;
            end
            else
            begin
                queue_step(SYM_INS, 1'b0);
                if (!ptr[PTR_INS_EXT])
                    st = WALK_MM;
                col--;
            end
        end
        // left the matrix edge: flag the final symbol
        path_due[path_due.size()-1].is_last = 1'b1;
    endtask

    // register writes, result compare, item prediction
    always @(posedge clk)
    begin
        path_step_t due;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_DIAG: diag_code = pwdata[1:0];
                    REG_UP:   up_code   = pwdata[1:0];
                    REG_LEFT: left_code = pwdata[1:0];
                    default:  ;
                endcase
            end
            if (valid)
            begin
                if (path_due.size() == 0)
                begin
                    $error("path_symbol %0d last %0d shown with no symbol due",
                           path_symbol, last);
                    mismatches++;
                end
                else
                begin
                    due = path_due.pop_front();
                    if (path_symbol !== due.symbol)
                    begin
                        $error("path_symbol: expected %0d, got %0d", due.symbol, path_symbol);
                        mismatches++;
                    end
                    if (last !== due.is_last)
                    begin
                        $error("last: expected %0d, got %0d", due.is_last, last);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (func)
                    trace_back(row_index, col_index);
                else if (row_index < QUERY_ROWS && col_index < REF_COLS)
                    cell_ptr[row_index*REF_COLS + col_index] = pointer_bits;
            end
        end
        symbols_due <= path_due.size();
    end

endmodule : affine_gap_traceback_checker
`default_nettype wire

### dv/affine_gap_traceback_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_gap_traceback_test
// Stimulus and verdict for the traceback block. Directed cells and starts
// hit each walk rule, then random paths are planned so every walk reads only
// written cells, mixed with stray writes, under several direction code sets
// including duplicate codes. The checker beside the block does the compare.
// ----------------------------------------------------------------------------
module affine_gap_traceback_test;
    timeunit 1ns;
    timeprecision 1ps;

    import agt_pkg::*;

    localparam int unsigned QUERY_ROWS   = 32;
    localparam int unsigned REF_COLS     = 32;
    localparam int unsigned PHASE_ITEMS  = 115;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned STALL_LIMIT  = 500;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   func = 1'b0;
    logic [4:0]             row_index = '0;
    logic [4:0]             col_index = '0;
    logic [3:0]             pointer_bits = '0;
    logic                   valid;
    logic [1:0]             path_symbol;
    logic                   last;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    int unsigned            fail_count;
    int unsigned            symbols_due;

    // stimulus side view of the store and codes, used to plan walks
    logic [3:0]   plan_ptr [QUERY_ROWS*REF_COLS];
    bit           plan_set [QUERY_ROWS*REF_COLS];
    logic [1:0]   plan_diag = DIAG_RESET;
    logic [1:0]   plan_up   = UP_RESET;
    logic [1:0]   plan_left = LEFT_RESET;
    bit           sender_gaps = 1'b1;
    int unsigned  items_sent = 0;
    int unsigned  stall_cycles = 0;

    affine_gap_traceback #(
        .QUERY_ROWS   (QUERY_ROWS),
        .REF_COLS     (REF_COLS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .row_index    (row_index),
        .col_index    (col_index),
        .pointer_bits (pointer_bits),
        .valid        (valid),
        .path_symbol  (path_symbol),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    affine_gap_traceback_checker #(
        .QUERY_ROWS   (QUERY_ROWS),
        .REF_COLS     (REF_COLS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .row_index    (row_index),
        .col_index    (col_index),
        .pointer_bits (pointer_bits),
        .valid        (valid),
        .path_symbol  (path_symbol),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .symbols_due  (symbols_due)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog on cycles with no traffic on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [3:0] ptr_of(input logic del_ext, input logic ins_ext,
                                          input logic [1:0] dir);
        return {del_ext, ins_ext, dir};
    endfunction

    // a direction that none of the current codes claims
    function automatic logic [1:0] unknown_dir();
        for (int d = 0; d < 4; d++)
        begin
            if (2'(d) != plan_diag && 2'(d) != plan_up && 2'(d) != plan_left)
                return 2'(d);
        end
        return plan_diag;
    endfunction

    function automatic logic route_of(input logic [1:0] dir, output logic [1:0] walk);
        walk = WALK_MM;
        if (dir == plan_diag)
            walk = WALK_MM;
        else if (dir == plan_up)
            walk = WALK_DEL;
        else if (dir == plan_left)
            walk = WALK_INS;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    // random pointer, biased toward diagonal moves while matching
    function automatic logic [3:0] pick_ptr(input logic in_match);
        logic [3:0] p;
        int         roll;
        p = 4'($urandom_range(15));
        if (in_match)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                p[1:0] = unknown_dir();
            else if (roll < 70)
                p[1:0] = plan_diag;
            else if (roll < 85)
                p[1:0] = plan_up;
            else
                p[1:0] = plan_left;
        end
        return p;
    endfunction

    // one item on the command channel, with start occasionally dropped before it while sender gaps are on
    task automatic send_item(input logic f, input logic [4:0] r, input logic [4:0] c,
                             input logic [3:0] p);
        if (sender_gaps && $urandom_range(99) < 6)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        func         <= f;
        row_index    <= r;
        col_index    <= c;
        pointer_bits <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_cell(input logic [4:0] r, input logic [4:0] c, input logic [3:0] p);
        plan_ptr[r*REF_COLS + c] = p;
        plan_set[r*REF_COLS + c] = 1'b1;
        send_item(1'b0, r, c, p);
    endtask

    // command channel low, all symbols in, then let the block settle
    task automatic wait_idle();
        @(posedge clk);
        while (symbols_due != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_code(input logic [1:0] index, input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_DIAG: plan_diag = value;
            REG_UP:   plan_up   = value;
            REG_LEFT: plan_left = value;
            default:  ;
        endcase
        @(posedge clk);
    endtask

    // fill any unwritten cell the walk will read, then start it
    task automatic run_path(input logic [4:0] r, input logic [4:0] c);
        int         row;
        int         col;
        logic [1:0] st;
        logic [1:0] nxt;
        logic [3:0] p;
        bit         done;
        row  = r;
        col  = c;
        st   = WALK_MM;
        done = 1'b0;
        while (!done && row >= 0 && col >= 0)
        begin
            if (!plan_set[row*REF_COLS + col])
                write_cell(5'(row), 5'(col), pick_ptr(st == WALK_MM));
            p = plan_ptr[row*REF_COLS + col];
            if (st == WALK_MM)
            begin
                if (!route_of(p[1:0], nxt))
                    done = 1'b1;
                else if (nxt == WALK_MM)
                begin
                    row--;
                    col--;
                end
                else
                    st = nxt;
            end
            else if (st == WALK_DEL)
            begin
                if (!p[PTR_DEL_EXT])
                    st = WALK_MM;
                row--;
            end
            else
            begin
                if (!p[PTR_INS_EXT])
                    st = WALK_MM;
                col--;
            end
        end
        send_item(1'b1, r, c, 4'($urandom_range(15)));
    endtask

    // planned paths, mostly small, with stray writes and drain pauses
    task automatic random_phase(input int unsigned count);
        int unsigned target;
        int          roll;
        target = items_sent + count;
        while (items_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
            begin
                start <= 1'b0;
                wait_idle();
            end
            else if (roll < 25)
                write_cell(5'($urandom_range(31)), 5'($urandom_range(31)),
                           4'($urandom_range(15)));
            else if ($urandom_range(99) < 85)
                run_path(5'($urandom_range(7)), 5'($urandom_range(7)));
            else
                run_path(5'($urandom_range(31)), 5'($urandom_range(31)));
        end
    endtask

    task automatic new_codes(input logic [1:0] diag, input logic [1:0] up,
                             input logic [1:0] left);
        start <= 1'b0;
        wait_idle();
        write_code(REG_DIAG, diag);
        write_code(REG_UP, up);
        write_code(REG_LEFT, left);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single diagonal step
        write_cell(5'd0, 5'd0, ptr_of(1'b0, 1'b0, DIAG_RESET));
        send_item(1'b1, 5'd0, 5'd0, 4'hF);
        // deletion off the top edge
        write_cell(5'd0, 5'd1, ptr_of(1'b1, 1'b0, UP_RESET));
        send_item(1'b1, 5'd0, 5'd1, 4'h0);
        // insertion off the left edge
        write_cell(5'd1, 5'd0, ptr_of(1'b0, 1'b1, LEFT_RESET));
        send_item(1'b1, 5'd1, 5'd0, 4'h0);
        // unknown direction at the end cell
        write_cell(5'd1, 5'd1, ptr_of(1'b1, 1'b1, unknown_dir()));
        send_item(1'b1, 5'd1, 5'd1, 4'h0);
        // match, then unknown direction in match state
        write_cell(5'd2, 5'd2, ptr_of(1'b0, 1'b1, DIAG_RESET));
        send_item(1'b1, 5'd2, 5'd2, 4'h0);
        // insertion back to match, then unknown direction
        write_cell(5'd1, 5'd2, ptr_of(1'b0, 1'b0, LEFT_RESET));
        send_item(1'b1, 5'd1, 5'd2, 4'h0);
        // deletion back to match, then a match off the edge
        write_cell(5'd1, 5'd3, ptr_of(1'b0, 1'b0, UP_RESET));
        write_cell(5'd0, 5'd3, ptr_of(1'b0, 1'b0, DIAG_RESET));
        send_item(1'b1, 5'd1, 5'd3, 4'h0);
        // far corner, all pointer bits set
        write_cell(5'd31, 5'd31, ptr_of(1'b1, 1'b1, unknown_dir()));
        send_item(1'b1, 5'd31, 5'd31, 4'hF);
        // extension bits at the edges
        write_cell(5'd0, 5'd31, ptr_of(1'b1, 1'b1, UP_RESET));
        send_item(1'b1, 5'd0, 5'd31, 4'h0);
        write_cell(5'd31, 5'd0, ptr_of(1'b0, 1'b0, LEFT_RESET));
        send_item(1'b1, 5'd31, 5'd0, 4'h0);

        random_phase(PHASE_ITEMS);

        // diag and up share a code, no sender gaps in this phase
        new_codes(2'd3, 2'd3, 2'd0);
        sender_gaps = 1'b0;
        random_phase(PHASE_ITEMS);

        // up and left share a code
        new_codes(2'd1, 2'd2, 2'd2);
        sender_gaps = 1'b1;
        random_phase(PHASE_ITEMS);

        new_codes(2'd2, 2'd0, 2'd3);
        random_phase(PHASE_ITEMS);

        start <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule : affine_gap_traceback_test
`default_nettype wire

### files.f
sv/agt_pkg.sv
sv/agt_ram.sv
sv/agt_cfg.sv
sv/affine_gap_traceback.sv
dv/affine_gap_traceback_checker.sv
dv/affine_gap_traceback_test.sv
